[hw/rtl/hsev_pkg.sv]
// ----------------------------------------------------------------------------
// hsev_pkg
// Shared types, command/status structs and the multiply program of the
// Hermite spline evaluator.
// ----------------------------------------------------------------------------
package hsev_pkg;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_VALUE = 2'd1,
      MODE_DERIV = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WRITE,
      S_WALK,
      S_RESOLVE,
      S_FETCH0,
      S_FETCH1,
      S_FETCH2,
      S_MUL_GO,
      S_MUL_WAIT,
      S_OUT
   } state_type;

   // one entry per multiply of the basis evaluation
   typedef enum logic [4:0] {
      OP_Z,
      OP_Z2,
      OP_OMZ2,
      OP_B00,
      OP_B01,
      OP_B10,
      OP_B11,
      OP_S2,
      OP_S3,
      OP_V0,
      OP_V1,
      OP_V2,
      OP_V3,
      OP_K,
      OP_D0,
      OP_D1,
      OP_D2,
      OP_D3
   } op_type;

   localparam logic [1:0] CSR_SEGMENT_COUNT = 2'd0;
   localparam logic [1:0] CSR_CURVE_START   = 2'd1;

   localparam logic [3:0] LAST_STEP_VALUE = 4'd12;
   localparam logic [3:0] LAST_STEP_DERIV = 4'd6;

   typedef struct packed {
      logic   load;
      logic   walk_init;
      logic   walk_run;
      logic   resolve;
      logic   knot_next;
      logic   cap_lo;
      logic   cap_hi;
      logic   mem_write;
      logic   mul_start;
      op_type mul_op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     walk_done;
      logic     mul_busy;
      logic     mul_done;
   } status_type;

   function automatic op_type op_for_step(input logic deriv, input logic [3:0] step);
      op_type op;
      op = OP_Z;
      if (deriv) begin
         case (step)
            4'd0:    op = OP_Z;
            4'd1:    op = OP_Z2;
            4'd2:    op = OP_K;
            4'd3:    op = OP_D0;
            4'd4:    op = OP_D1;
            4'd5:    op = OP_D2;
            default: op = OP_D3;
         endcase
      end else begin
         case (step)
            4'd0:    op = OP_Z;
            4'd1:    op = OP_Z2;
            4'd2:    op = OP_OMZ2;
            4'd3:    op = OP_B00;
            4'd4:    op = OP_B01;
            4'd5:    op = OP_B10;
            4'd6:    op = OP_B11;
            4'd7:    op = OP_S2;
            4'd8:    op = OP_S3;
            4'd9:    op = OP_V0;
            4'd10:   op = OP_V1;
            4'd11:   op = OP_V2;
            default: op = OP_V3;
         endcase
      end
      return op;
   endfunction

endpackage

[hw/rtl/hermite_spline_evaluator_core.sv]
// ----------------------------------------------------------------------------
// hermite_spline_evaluator_core
// Piecewise cubic Hermite spline evaluator, signed Q16.16 fixed point.
// A knot write gives a result word of zeros, as does spare mode. Evaluation runs decode,
// walk, fetch and output, plus the multiply program: 13 multiplies for a value, 7 for
// a derivative; the walk steps through the segments in use.
// One word in work at a time; the next can be accepted in the cycle the result goes
// valid, and a result still held by the receiver stalls the output step.
// Reset clears the sequencer and configuration; knot memories are not cleared.
// ----------------------------------------------------------------------------
module hermite_spline_evaluator_core #(
   parameter int MAX_SEGMENTS  = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: entry_index[6:0], argument[38:7], knot_value[70:39],
   //        knot_slope[102:71], interval_length[133:103],
   //        interval_inverse[164:134], zero pad [167:165]
   input  logic [167:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]   req_tuser,
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: result_value[31:0], segment_used[37:32], below_range[38],
   //        above_range[39], saturated[40], zero pad [47:41]
   output logic [47:0]  rsp_tdata,
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   hsev_pkg::cmd_type    cmd;
   hsev_pkg::status_type status;

   logic signed [31:0] result_value;
   logic [5:0]         segment_used;
   logic               below_range, above_range, saturated;

   // register writes are taken at any time; software writes only when idle
   assign csr_ready = 1'b1;

   hsev_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   hsev_datapath #(
      .MAX_SEGMENTS  (MAX_SEGMENTS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .mode             (req_tuser),
      .entry_index      (req_tdata[6:0]),
      .argument         (signed'(req_tdata[38:7])),
      .knot_value       (signed'(req_tdata[70:39])),
      .knot_slope       (signed'(req_tdata[102:71])),
      .interval_length  (req_tdata[133:103]),
      .interval_inverse (req_tdata[164:134]),
      .csr_valid        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .result_value     (result_value),
      .segment_used     (segment_used),
      .below_range      (below_range),
      .above_range      (above_range),
      .saturated        (saturated)
   );

   // pack the result word, flags above the value
   assign rsp_tdata = {7'd0, saturated, above_range, below_range, segment_used,
                       result_value};

endmodule

[hw/rtl/hsev_mul.sv]
// ----------------------------------------------------------------------------
// hsev_mul
// Sequential signed fixed-point multiplier: four 32x32 partial products,
// floor shift by the fraction width, saturation to +-2^56.
// ----------------------------------------------------------------------------
module hsev_mul #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   output logic               busy,
   output logic               done,
   output logic signed [63:0] product,
   output logic               overflow
);

   localparam int QW = 128 - FRACTION_BITS;
   localparam logic [QW-1:0] LIMIT = QW'(1) << 56;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [2:0]    step_ff, step_in;
   logic [63:0]   mag_a_ff, mag_a_in;
   logic [63:0]   mag_b_ff, mag_b_in;
   logic          neg_ff, neg_in;
   logic [63:0]   pp_ff, pp_in;
   logic [1:0]    sh_ff, sh_in;
   logic [127:0]  acc_ff, acc_in;
   logic [QW-1:0] q_ff, q_in;
   logic [63:0]   prod_ff, prod_in;
   logic          ovf_ff, ovf_in;

   logic [31:0]   a_part, b_part;
   logic [127:0]  pp_wide;
   logic          rem_nz;
   logic          q_sat;
   logic [QW-1:0] q_lim;

   always_comb begin
      a_part  = step_ff[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      b_part  = step_ff[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_wide = {64'd0, pp_ff};
         2'd1:    pp_wide = {32'd0, pp_ff, 32'd0};
         default: pp_wide = {pp_ff, 64'd0};
      endcase
      rem_nz = |acc_ff[FRACTION_BITS-1:0];
      q_sat  = q_ff > LIMIT;
      q_lim  = q_sat ? LIMIT : q_ff;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      ovf_in   = ovf_ff;
      if (!busy_ff) begin
         if (start) begin
            mag_a_in = op_a[63] ? 64'(-op_a) : 64'(op_a);
            mag_b_in = op_b[63] ? 64'(-op_b) : 64'(op_b);
            neg_in   = op_a[63] ^ op_b[63];
            acc_in   = '0;
            step_in  = 3'd0;
            busy_in  = 1'b1;
         end
      end else begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            3'd0, 3'd1, 3'd2, 3'd3: begin
               pp_in = a_part * b_part;
               sh_in = {step_ff[1] & step_ff[0], step_ff[1] ^ step_ff[0]};
               if (step_ff != 3'd0) begin
                  acc_in = acc_ff + pp_wide;
               end
            end
            3'd4: acc_in = acc_ff + pp_wide;
            3'd5: q_in = acc_ff[127:FRACTION_BITS] + QW'(neg_ff & rem_nz);
            default: begin
               // clip the magnitude, then apply the sign
               prod_in = neg_ff ? -64'(q_lim) : 64'(q_lim);
               ovf_in  = q_sat;
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      pp_ff    <= pp_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      prod_ff  <= prod_in;
      ovf_ff   <= ovf_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign product  = signed'(prod_ff);
   assign overflow = ovf_ff;

endmodule

[hw/rtl/hsev_datapath.sv]
// ----------------------------------------------------------------------------
// hsev_datapath
// Knot and interval memories, configuration registers, interval walk,
// basis operand selection, accumulation and the result register.
// ----------------------------------------------------------------------------
module hsev_datapath #(
   parameter int MAX_SEGMENTS  = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  hsev_pkg::cmd_type    cmd,
   output hsev_pkg::status_type status,
   input  logic [1:0]          mode,
   input  logic [6:0]          entry_index,
   input  logic signed [31:0]  argument,
   input  logic signed [31:0]  knot_value,
   input  logic signed [31:0]  knot_slope,
   input  logic [30:0]         interval_length,
   input  logic [30:0]         interval_inverse,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic signed [31:0]  result_value,
   output logic [5:0]          segment_used,
   output logic                below_range,
   output logic                above_range,
   output logic                saturated
);

   localparam int KW = $clog2(MAX_SEGMENTS + 1);
   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic signed [63:0] ONE   = 64'sd1 <<< FRACTION_BITS;
   localparam logic signed [63:0] THREE = ONE * 64'sd3;

   // configuration
   logic [6:0]         seg_count_ff;
   logic signed [31:0] curve_start_ff;

   // item
   hsev_pkg::mode_type mode_ff;
   logic [6:0]         idx_ff;
   logic signed [31:0] arg_ff, kval_ff, kslope_ff;
   logic [30:0]        ilen_ff, iinv_ff;

   // memories
   logic [63:0]   knot_mem [MAX_SEGMENTS+1];
   logic [61:0]   int_mem  [MAX_SEGMENTS];
   logic [63:0]   knot_rd_ff;
   logic [61:0]   int_rd_ff;
   logic [KW-1:0] knot_rd_addr;
   logic [IW-1:0] int_rd_addr;
   logic          knot_wr_ok, int_wr_ok;

   // walk
   logic [KW-1:0]      n_val;
   logic [KW-1:0]      issue_cnt_ff, proc_idx_ff, found_seg_ff;
   logic               issue_vld_ff, found_ff;
   logic signed [47:0] theta_ff, last_start_ff, found_start_ff;
   logic signed [47:0] t48, start48, len48, theta_end;

   // segment
   logic [KW-1:0]      seg_ff;
   logic signed [47:0] seg_start_ff;
   logic               below_ff, above_ff;
   logic signed [31:0] f0_ff, f1_ff, f2_ff, f3_ff;
   logic [30:0]        hl_ff, inv_ff;

   // basis
   logic signed [63:0] z_ff, z2_ff, w_ff, b00_ff, b01_ff, b10_ff, b11_ff, s2_ff, s3_ff;
   logic signed [63:0] acc_ff;
   logic               sat_ff;
   hsev_pkg::op_type   op_ff;
   logic signed [63:0] mul_a, mul_b, mul_p;
   logic signed [63:0] omz, diff64, hl64, inv64;
   logic               mul_busy, mul_done, mul_ovf;

   // result
   logic signed [31:0] res_value_ff;
   logic [5:0]         res_seg_ff;
   logic               res_below_ff, res_above_ff, res_sat_ff;

   function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
      return signed'({{32{v[31]}}, v});
   endfunction

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff   <= 7'd1;
         curve_start_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            hsev_pkg::CSR_SEGMENT_COUNT: seg_count_ff   <= csr_data[6:0];
            hsev_pkg::CSR_CURVE_START:   curve_start_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (seg_count_ff == 7'd0) begin
         n_val = KW'(1);
      end else if (32'(seg_count_ff) > 32'(MAX_SEGMENTS)) begin
         n_val = KW'(MAX_SEGMENTS);
      end else begin
         n_val = KW'(seg_count_ff);
      end
   end

   // ---------------- item capture ----------------
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= hsev_pkg::mode_type'(mode);
         idx_ff    <= entry_index;
         arg_ff    <= argument;
         kval_ff   <= knot_value;
         kslope_ff <= knot_slope;
         ilen_ff   <= interval_length;
         iinv_ff   <= interval_inverse;
      end
   end

   // ---------------- memories ----------------
   assign knot_wr_ok   = 32'(idx_ff) <= 32'(MAX_SEGMENTS);
   assign int_wr_ok    = 32'(idx_ff) < 32'(MAX_SEGMENTS);
   assign knot_rd_addr = cmd.knot_next ? seg_ff + KW'(1) : seg_ff;
   assign int_rd_addr  = cmd.walk_run ? issue_cnt_ff[IW-1:0] : seg_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_write && knot_wr_ok) begin
         knot_mem[KW'(idx_ff)] <= {kslope_ff, kval_ff};
      end
      knot_rd_ff <= knot_mem[knot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && int_wr_ok) begin
         int_mem[IW'(idx_ff)] <= {iinv_ff, ilen_ff};
      end
      int_rd_ff <= int_mem[int_rd_addr];
   end

   // ---------------- interval walk ----------------
   assign t48       = signed'({{16{arg_ff[31]}}, arg_ff});
   assign start48   = signed'({{16{curve_start_ff[31]}}, curve_start_ff});
   assign len48     = signed'({17'd0, int_rd_ff[30:0]});
   assign theta_end = theta_ff + len48;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_vld_ff <= 1'b0;
      end else if (cmd.walk_run && issue_cnt_ff != n_val) begin
         issue_vld_ff <= 1'b1;
      end else begin
         issue_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         issue_cnt_ff  <= '0;
         theta_ff      <= start48;
         last_start_ff <= start48;
         found_ff      <= 1'b0;
      end else begin
         if (cmd.walk_run && issue_cnt_ff != n_val) begin
            proc_idx_ff  <= issue_cnt_ff;
            issue_cnt_ff <= issue_cnt_ff + KW'(1);
         end
         if (issue_vld_ff) begin
            theta_ff      <= theta_end;
            last_start_ff <= theta_ff;
            // lowest closed interval holding the argument wins
            if (!found_ff && t48 >= theta_ff && t48 <= theta_end) begin
               found_ff       <= 1'b1;
               found_seg_ff   <= proc_idx_ff;
               found_start_ff <= theta_ff;
            end
         end
      end
   end

   // ---------------- segment decision and fetch ----------------
   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         below_ff <= 1'b0;
         above_ff <= 1'b0;
         if (t48 < start48) begin
            below_ff     <= 1'b1;
            seg_ff       <= '0;
            seg_start_ff <= start48;
         end else if (t48 > theta_ff) begin
            above_ff     <= 1'b1;
            seg_ff       <= n_val - KW'(1);
            seg_start_ff <= last_start_ff;
         end else if (found_ff) begin
            seg_ff       <= found_seg_ff;
            seg_start_ff <= found_start_ff;
         end else begin
            seg_ff       <= n_val - KW'(1);
            seg_start_ff <= last_start_ff;
         end
      end
      if (cmd.cap_lo) begin
         hl_ff  <= int_rd_ff[30:0];
         inv_ff <= int_rd_ff[61:31];
         f0_ff  <= signed'(knot_rd_ff[31:0]);
         f2_ff  <= signed'(knot_rd_ff[63:32]);
      end
      if (cmd.cap_hi) begin
         f1_ff <= signed'(knot_rd_ff[31:0]);
         f3_ff <= signed'(knot_rd_ff[63:32]);
      end
   end

   // ---------------- operand selection ----------------
   assign omz    = ONE - z_ff;
   assign diff64 = 64'(t48 - seg_start_ff);
   assign hl64   = signed'({33'd0, hl_ff});
   assign inv64  = signed'({33'd0, inv_ff});

   always_comb begin
      mul_a = z_ff;
      mul_b = z_ff;
      case (cmd.mul_op)
         hsev_pkg::OP_Z:    begin mul_a = diff64;       mul_b = inv64;    end
         hsev_pkg::OP_Z2:   begin mul_a = z_ff;         mul_b = z_ff;     end
         hsev_pkg::OP_OMZ2: begin mul_a = omz;          mul_b = omz;      end
         hsev_pkg::OP_B00:  begin mul_a = w_ff;         mul_b = (z_ff <<< 1) + ONE; end
         hsev_pkg::OP_B01:  begin mul_a = z2_ff;        mul_b = THREE - (z_ff <<< 1); end
         hsev_pkg::OP_B10:  begin mul_a = z_ff;         mul_b = w_ff;     end
         hsev_pkg::OP_B11:  begin mul_a = omz;          mul_b = z2_ff;    end
         hsev_pkg::OP_S2:   begin mul_a = sx32(f2_ff);  mul_b = hl64;     end
         hsev_pkg::OP_S3:   begin mul_a = sx32(f3_ff);  mul_b = hl64;     end
         hsev_pkg::OP_V0:   begin mul_a = sx32(f0_ff);  mul_b = b00_ff;   end
         hsev_pkg::OP_V1:   begin mul_a = sx32(f1_ff);  mul_b = b01_ff;   end
         hsev_pkg::OP_V2:   begin mul_a = s2_ff;        mul_b = b10_ff;   end
         hsev_pkg::OP_V3:   begin mul_a = s3_ff;        mul_b = b11_ff;   end
         hsev_pkg::OP_K: begin
            mul_a = (z2_ff <<< 2) + (z2_ff <<< 1) - (z_ff <<< 2) - (z_ff <<< 1);
            mul_b = inv64;
         end
         hsev_pkg::OP_D0:   begin mul_a = sx32(f0_ff);  mul_b = w_ff;     end
         hsev_pkg::OP_D1:   begin mul_a = sx32(f1_ff);  mul_b = w_ff;     end
         hsev_pkg::OP_D2: begin
            mul_a = sx32(f2_ff);
            mul_b = ONE - (z_ff <<< 2) + (z2_ff <<< 1) + z2_ff;
         end
         hsev_pkg::OP_D3: begin
            mul_a = sx32(f3_ff);
            mul_b = (z2_ff <<< 1) + z2_ff - (z_ff <<< 1);
         end
         default: ;
      endcase
   end

   hsev_mul #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mul_start),
      .op_a     (mul_a),
      .op_b     (mul_b),
      .busy     (mul_busy),
      .done     (mul_done),
      .product  (mul_p),
      .overflow (mul_ovf)
   );

   // ---------------- product write-back ----------------
   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         op_ff <= cmd.mul_op;
      end
      if (cmd.load) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (mul_done) begin
         sat_ff <= sat_ff | mul_ovf;
         case (op_ff)
            hsev_pkg::OP_Z:    z_ff   <= mul_p;
            hsev_pkg::OP_Z2:   z2_ff  <= mul_p;
            hsev_pkg::OP_OMZ2: w_ff   <= mul_p;
            hsev_pkg::OP_K:    w_ff   <= mul_p;
            hsev_pkg::OP_B00:  b00_ff <= mul_p;
            hsev_pkg::OP_B01:  b01_ff <= mul_p;
            hsev_pkg::OP_B10:  b10_ff <= mul_p;
            hsev_pkg::OP_B11:  b11_ff <= -mul_p;
            hsev_pkg::OP_S2:   s2_ff  <= mul_p;
            hsev_pkg::OP_S3:   s3_ff  <= mul_p;
            hsev_pkg::OP_D1:   acc_ff <= acc_ff - mul_p;
            default:           acc_ff <= acc_ff + mul_p;
         endcase
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (mode_ff == hsev_pkg::MODE_VALUE || mode_ff == hsev_pkg::MODE_DERIV) begin
            res_seg_ff   <= 6'(seg_ff);
            res_below_ff <= below_ff;
            res_above_ff <= above_ff;
            if (acc_ff > 64'sh7FFF_FFFF) begin
               res_value_ff <= 32'sh7FFF_FFFF;
               res_sat_ff   <= 1'b1;
            end else if (acc_ff < -64'sh8000_0000) begin
               res_value_ff <= signed'(32'h8000_0000);
               res_sat_ff   <= 1'b1;
            end else begin
               res_value_ff <= acc_ff[31:0];
               res_sat_ff   <= sat_ff;
            end
         end else begin
            res_value_ff <= '0;
            res_seg_ff   <= '0;
            res_below_ff <= 1'b0;
            res_above_ff <= 1'b0;
            res_sat_ff   <= 1'b0;
         end
      end
   end

   assign result_value = res_value_ff;
   assign segment_used = res_seg_ff;
   assign below_range  = res_below_ff;
   assign above_range  = res_above_ff;
   assign saturated    = res_sat_ff;

   assign status.mode      = mode_ff;
   assign status.walk_done = (issue_cnt_ff == n_val) && !issue_vld_ff;
   assign status.mul_busy  = mul_busy;
   assign status.mul_done  = mul_done;

endmodule

[hw/rtl/hsev_ctrl.sv]
// ----------------------------------------------------------------------------
// hsev_ctrl
// Sequencer: decodes the word, runs the walk, fetch and multiply program,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module hsev_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output hsev_pkg::cmd_type    cmd,
   input  hsev_pkg::status_type status
);

   hsev_pkg::state_type state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                deriv;
   logic [3:0]          last_step;
   logic                evaluate;

   assign deriv     = status.mode == hsev_pkg::MODE_DERIV;
   assign evaluate  = status.mode == hsev_pkg::MODE_VALUE || deriv;
   assign last_step = deriv ? hsev_pkg::LAST_STEP_DERIV : hsev_pkg::LAST_STEP_VALUE;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         hsev_pkg::S_IDLE:   if (req_tvalid) state_in = hsev_pkg::S_DECODE;
         hsev_pkg::S_DECODE: begin
            if (status.mode == hsev_pkg::MODE_WRITE) begin
               state_in = hsev_pkg::S_WRITE;
            end else if (evaluate) begin
               state_in = hsev_pkg::S_WALK;
            end else begin
               state_in = hsev_pkg::S_OUT;
            end
         end
         hsev_pkg::S_WRITE:   state_in = hsev_pkg::S_OUT;
         hsev_pkg::S_WALK:    if (status.walk_done) state_in = hsev_pkg::S_RESOLVE;
         hsev_pkg::S_RESOLVE: state_in = hsev_pkg::S_FETCH0;
         hsev_pkg::S_FETCH0:  state_in = hsev_pkg::S_FETCH1;
         hsev_pkg::S_FETCH1:  state_in = hsev_pkg::S_FETCH2;
         hsev_pkg::S_FETCH2: begin
            step_in  = 4'd0;
            state_in = hsev_pkg::S_MUL_GO;
         end
         hsev_pkg::S_MUL_GO:  state_in = hsev_pkg::S_MUL_WAIT;
         hsev_pkg::S_MUL_WAIT: begin
            if (status.mul_done) begin
               if (step_ff == last_step) begin
                  state_in = hsev_pkg::S_OUT;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = hsev_pkg::S_MUL_GO;
               end
            end
         end
         hsev_pkg::S_OUT: if (!rsp_valid_ff || rsp_tready) state_in = hsev_pkg::S_IDLE;
         default: state_in = hsev_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.mul_op = hsev_pkg::op_for_step(deriv, step_ff);
      req_tready = 1'b0;
      case (state_ff)
         hsev_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hsev_pkg::S_DECODE:   cmd.walk_init = evaluate;
         hsev_pkg::S_WRITE:    cmd.mem_write = 1'b1;
         hsev_pkg::S_WALK:     cmd.walk_run  = 1'b1;
         hsev_pkg::S_RESOLVE:  cmd.resolve   = 1'b1;
         hsev_pkg::S_FETCH1: begin
            cmd.knot_next = 1'b1;
            cmd.cap_lo    = 1'b1;
         end
         hsev_pkg::S_FETCH2:   cmd.cap_hi    = 1'b1;
         hsev_pkg::S_MUL_GO:   cmd.mul_start = 1'b1;
         hsev_pkg::S_OUT:      cmd.out_load  = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsev_pkg::S_IDLE;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy)
      else $error("multiply started while the unit is busy");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> state_ff == hsev_pkg::S_MUL_WAIT)
      else $error("product arrived outside the wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("second word accepted while one is in work");

endmodule
